/* src/bhf_pkg.sv */
// ----------------------------------------------------------------------------
// bhf_pkg: shared types and constants of the byte histogram
// Request layout, case-folding codes and register indexes.
// ----------------------------------------------------------------------------
package bhf_pkg;

  // number of bins, one per byte value
  localparam int unsigned BINS     = 32'h100;
  localparam int unsigned BIN_W    = $clog2(BINS);
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned MASK_REGS = BINS / MASK_W;

  // distance between ascii upper and lower case letters
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] UPPER_LO   = 8'h41;
  localparam logic [7:0] UPPER_HI   = 8'h5A;
  localparam logic [7:0] LOWER_LO   = 8'h61;
  localparam logic [7:0] LOWER_HI   = 8'h7A;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_3    = 3'd4;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    CASE_KEEP  = 2'd0,
    CASE_LOWER = 2'd1,
    CASE_UPPER = 2'd2
  } case_mode_e;

  typedef enum logic {
    ACT_COUNT = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  // classified request handed from the front to the back
  typedef struct packed {
    logic             is_count;
    logic             incl;
    logic [BIN_W-1:0] bin;
  } req_t;

endpackage

/* src/byte_histogram_with_filter.sv */
// ----------------------------------------------------------------------------
// byte_histogram_with_filter: filtered byte value histogram
// Counts case-folded bytes into 256 saturating bins plus a running total.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ---------------------------------
// in        in         in_valid_i / in_ready_o   action_i, data_byte_i, bin_index_i
// out       out        out_valid_o / out_ready_i counted_o, bin_count_o,
//                                                bin_included_o, total_count_o
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one request per cycle sustained while the output is not stalled; a result passes
// through the queue slot, the bin ram read, then the update into the output register
// the bin ram read-modify-write loop sets the rate; the last write is
// forwarded so back-to-back hits on one bin need no bubble
// reset sets config defaults, clears total and per-bin written flags; no clearing pass
// a stalled output fills the two-entry queue, then in_ready_o drops
//
module byte_histogram_with_filter #(
  parameter int unsigned CountWidth = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [7:0]                    data_byte_i,
  input  logic [7:0]                    bin_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          counted_o,
  output logic [CountWidth-1:0]         bin_count_o,
  output logic                          bin_included_o,
  output logic [CountWidth-1:0]         total_count_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bhf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bhf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  bhf_pkg::case_mode_e        case_mode_q;
  logic [bhf_pkg::MASK_W-1:0] mask_q [bhf_pkg::MASK_REGS];
  logic [bhf_pkg::BINS-1:0]   include_mask;
  logic                       cfg_write;

  // front to queue
  bhf_pkg::req_t front_req;
  logic          q_full;

  // queue to back
  logic          q_empty;
  logic          q_pop;
  bhf_pkg::req_t q_data;

  // writes are always accepted
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_mode_q <= bhf_pkg::CASE_KEEP;
      for (int i = 0; i < bhf_pkg::MASK_REGS; i++) begin
        mask_q[i] <= '1;
      end
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        bhf_pkg::CFG_CASE_MODE: case_mode_q <= bhf_pkg::case_mode_e'(cfg_data_i[1:0]);
        bhf_pkg::CFG_MASK_0:    mask_q[0]   <= cfg_data_i;
        bhf_pkg::CFG_MASK_1:    mask_q[1]   <= cfg_data_i;
        bhf_pkg::CFG_MASK_2:    mask_q[2]   <= cfg_data_i;
        bhf_pkg::CFG_MASK_3:    mask_q[3]   <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // bit n of the flat mask is byte value n
  always_comb begin
    for (int i = 0; i < bhf_pkg::MASK_REGS; i++) begin
      include_mask[i*bhf_pkg::MASK_W +: bhf_pkg::MASK_W] = mask_q[i];
    end
  end

  // classify: fold case, choose bin, look up include bit
  bhf_front u_front (
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .bin_index_i    (bin_index_i),
    .case_mode_i    (case_mode_q),
    .include_mask_i (include_mask),
    .req_o          (front_req)
  );

  assign in_ready_o = !q_full;

  // short queue lets front and back stall independently
  bhf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  // bin read-modify-write, total and result register
  bhf_back #(
    .CountWidth (CountWidth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .counted_o      (counted_o),
    .bin_count_o    (bin_count_o),
    .bin_included_o (bin_included_o),
    .total_count_o  (total_count_o)
  );

endmodule

/* src/bhf_ram.sv */
// ----------------------------------------------------------------------------
// bhf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bhf_front.sv */
// ----------------------------------------------------------------------------
// bhf_front: request classifier
// Folds letter case, picks the bin and looks up its include bit.
// ----------------------------------------------------------------------------
module bhf_front (
  input  logic                     action_i,
  input  logic [7:0]               data_byte_i,
  input  logic [7:0]               bin_index_i,
  input  bhf_pkg::case_mode_e      case_mode_i,
  input  logic [bhf_pkg::BINS-1:0] include_mask_i,
  output bhf_pkg::req_t            req_o
);

  logic [7:0] folded;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] bin;

  assign is_upper = (data_byte_i >= bhf_pkg::UPPER_LO) && (data_byte_i <= bhf_pkg::UPPER_HI);
  assign is_lower = (data_byte_i >= bhf_pkg::LOWER_LO) && (data_byte_i <= bhf_pkg::LOWER_HI);

  always_comb begin
    folded = data_byte_i;
    unique case (case_mode_i)
      bhf_pkg::CASE_LOWER: begin
        if (is_upper) folded = data_byte_i + bhf_pkg::CASE_DELTA;
      end
      bhf_pkg::CASE_UPPER: begin
        if (is_lower) folded = data_byte_i - bhf_pkg::CASE_DELTA;
      end
      default: folded = data_byte_i;
    endcase
  end

  assign bin = (action_i == bhf_pkg::ACT_READ) ? bin_index_i : folded;

  assign req_o.is_count = (action_i == bhf_pkg::ACT_COUNT);
  assign req_o.bin      = bin[bhf_pkg::BIN_W-1:0];
  assign req_o.incl     = include_mask_i[bin[bhf_pkg::BIN_W-1:0]];

endmodule

/* src/bhf_queue.sv */
// ----------------------------------------------------------------------------
// bhf_queue: two-entry request queue
// Decouples the classifier from the bin update pipeline.
// ----------------------------------------------------------------------------
module bhf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bhf_pkg::req_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bhf_pkg::req_t pop_data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  bhf_pkg::req_t     slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o     = (fill_q == (PtrW+1)'(Depth));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + (PtrW+1)'(1);
    if (do_pop && !do_push) fill_d = fill_q - (PtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/bhf_back.sv */
// ----------------------------------------------------------------------------
// bhf_back: bin update pipeline
// Reads the bin, increments with saturation, writes back and registers the result.
// ----------------------------------------------------------------------------
module bhf_back #(
  parameter int unsigned CountWidth = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  bhf_pkg::req_t         q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  counted_o,
  output logic [CountWidth-1:0] bin_count_o,
  output logic                  bin_included_o,
  output logic [CountWidth-1:0] total_count_o
);

  localparam int unsigned BinW = bhf_pkg::BIN_W;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // read stage
  logic                  rd_valid_q, rd_valid_d;
  bhf_pkg::req_t         rd_req_q;
  logic                  issue, advance;
  logic [CountWidth-1:0] ram_rdata;

  // last write, forwarded over the ram read latency
  logic                  lw_valid_q;
  logic [BinW-1:0]       lw_addr_q;
  logic [CountWidth-1:0] lw_data_q;

  // entries never written read as zero
  logic [bhf_pkg::BINS-1:0] written_q;

  logic [CountWidth-1:0] cur_count, new_count;
  logic [CountWidth-1:0] total_q, new_total;
  logic                  do_inc;

  logic                  out_valid_q, out_valid_d;
  logic                  counted_q;
  logic [CountWidth-1:0] bin_count_q;
  logic                  bin_included_q;
  logic [CountWidth-1:0] total_count_q;

  assign advance = rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue   = !q_empty_i && (!rd_valid_q || advance);
  assign q_pop_o = issue;

  bhf_ram #(
    .Width (CountWidth),
    .Depth (bhf_pkg::BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (advance && do_inc),
    .waddr_i (rd_req_q.bin),
    .wdata_i (new_count),
    .re_i    (issue),
    .raddr_i (q_data_i.bin),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (lw_valid_q && (lw_addr_q == rd_req_q.bin)) begin
      cur_count = lw_data_q;
    end else if (written_q[rd_req_q.bin]) begin
      cur_count = ram_rdata;
    end else begin
      cur_count = '0;
    end
  end

  assign do_inc    = rd_req_q.is_count && rd_req_q.incl;
  assign new_count = (do_inc && (cur_count != CountMax)) ? cur_count + CountWidth'(1)
                                                         : cur_count;
  assign new_total = (do_inc && (total_q != CountMax)) ? total_q + CountWidth'(1)
                                                       : total_q;

  always_comb begin
    rd_valid_d = rd_valid_q;
    if (issue)        rd_valid_d = 1'b1;
    else if (advance) rd_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
      written_q   <= '0;
      total_q     <= '0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && do_inc) begin
        lw_valid_q               <= 1'b1;
        written_q[rd_req_q.bin]  <= 1'b1;
        total_q                  <= new_total;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_req_q <= q_data_i;
    end
    if (advance && do_inc) begin
      lw_addr_q <= rd_req_q.bin;
      lw_data_q <= new_count;
    end
    if (advance) begin
      counted_q      <= do_inc;
      bin_count_q    <= new_count;
      bin_included_q <= rd_req_q.incl;
      total_count_q  <= new_total;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign counted_o      = counted_q;
  assign bin_count_o    = bin_count_q;
  assign bin_included_o = bin_included_q;
  assign total_count_o  = total_count_q;

endmodule

/* tb/byte_histogram_with_filter_checker.sv */
// ----------------------------------------------------------------------------
// byte_histogram_with_filter_checker: result checker for the byte histogram
// Follows register writes and accepted requests, keeps its own bins and total,
// and compares each accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module byte_histogram_with_filter_checker #(
  parameter int unsigned CountWidth = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           action_i,
  input  logic [7:0]                     data_byte_i,
  input  logic [7:0]                     bin_index_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           counted_i,
  input  logic [CountWidth-1:0]          bin_count_i,
  input  logic                           bin_included_i,
  input  logic [CountWidth-1:0]          total_count_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bhf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bhf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             failures_o,
  output int                             pending_o,
  output int                             results_o
);

  localparam logic [CountWidth-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  counted;
    logic [CountWidth-1:0] count;
    logic                  included;
    logic [CountWidth-1:0] total;
  } hist_readout_t;

  logic [1:0]                 fold_mode;
  logic [bhf_pkg::MASK_W-1:0] keep_mask [bhf_pkg::MASK_REGS];
  logic [CountWidth-1:0]      bin_tally [bhf_pkg::BINS];
  logic [CountWidth-1:0]      byte_total;
  hist_readout_t              readouts_due [$];
  hist_readout_t              want;

  initial begin
    failures_o = 0;
    pending_o  = 0;
    results_o  = 0;
  end

  function automatic logic [7:0] fold_letter(logic [7:0] raw);
    if (fold_mode == bhf_pkg::CASE_UPPER && raw >= bhf_pkg::LOWER_LO &&
        raw <= bhf_pkg::LOWER_HI) begin
      return raw - bhf_pkg::CASE_DELTA;
    end
    if (fold_mode == bhf_pkg::CASE_LOWER && raw >= bhf_pkg::UPPER_LO &&
        raw <= bhf_pkg::UPPER_HI) begin
      return raw + bhf_pkg::CASE_DELTA;
    end
    return raw;
  endfunction

  function automatic logic [CountWidth-1:0] bump(logic [CountWidth-1:0] value);
    return (value == COUNT_MAX) ? value : value + 1'b1;
  endfunction

  // applies one request to the local bins and returns the readout it gives
  function automatic hist_readout_t tally_request(logic act, logic [7:0] raw,
                                                  logic [7:0] idx);
    logic [7:0]    bin;
    hist_readout_t r;
    r = '0;
    if (act == bhf_pkg::ACT_COUNT) begin
      bin        = fold_letter(raw);
      r.included = keep_mask[bin[7:6]][bin[5:0]];
      if (r.included) begin
        bin_tally[bin] = bump(bin_tally[bin]);
        byte_total     = bump(byte_total);
        r.counted      = 1'b1;
      end
    end else begin
      bin        = idx;
      r.included = keep_mask[bin[7:6]][bin[5:0]];
    end
    r.count = bin_tally[bin];
    r.total = byte_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch on result %0d: %s is %0h, predicted %0h",
             results_o, what, got, exp_val);
    failures_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_mode  = bhf_pkg::CASE_KEEP;
      byte_total = '0;
      for (int i = 0; i < bhf_pkg::MASK_REGS; i++) keep_mask[i] = '1;
      for (int i = 0; i < bhf_pkg::BINS; i++) bin_tally[i] = '0;
      readouts_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bhf_pkg::CFG_CASE_MODE: fold_mode    = cfg_data_i[1:0];
          bhf_pkg::CFG_MASK_0:    keep_mask[0] = cfg_data_i;
          bhf_pkg::CFG_MASK_1:    keep_mask[1] = cfg_data_i;
          bhf_pkg::CFG_MASK_2:    keep_mask[2] = cfg_data_i;
          bhf_pkg::CFG_MASK_3:    keep_mask[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (readouts_due.size() == 0) begin
          report_mismatch("result with nothing pending, bin count",
                          64'(bin_count_i), '0);
        end else begin
          want = readouts_due.pop_front();
          if (counted_i !== want.counted) begin
            report_mismatch("counted", 64'(counted_i), 64'(want.counted));
          end
          if (bin_count_i !== want.count) begin
            report_mismatch("bin count", 64'(bin_count_i), 64'(want.count));
          end
          if (bin_included_i !== want.included) begin
            report_mismatch("bin included", 64'(bin_included_i), 64'(want.included));
          end
          if (total_count_i !== want.total) begin
            report_mismatch("total count", 64'(total_count_i), 64'(want.total));
          end
        end
        results_o++;
      end
      if (in_valid_i && in_ready_i) begin
        readouts_due.push_back(tally_request(action_i, data_byte_i, bin_index_i));
      end
      pending_o = readouts_due.size();
    end
  end

endmodule

/* tb/byte_histogram_with_filter_test.sv */
// ----------------------------------------------------------------------------
// byte_histogram_with_filter_test: top level of the byte histogram testbench
// Drives requests and register writes with random gaps and stalls, lets the
// checker predict and compare every result, then gives the verdict.
// ----------------------------------------------------------------------------
module byte_histogram_with_filter_test;

  // counters at their full width
  localparam int unsigned COUNT_W       = 64;
  localparam int unsigned IDX_W         = bhf_pkg::CFG_IDX_W;
  // case mode value with no folding defined, must behave as no change
  localparam logic [1:0]  CASE_SPARE    = 2'd3;
  localparam int unsigned STALL_MAX     = 11;
  localparam int unsigned QUIET_LIMIT   = 500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 100;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           action_i;
  logic [7:0]                     data_byte_i;
  logic [7:0]                     bin_index_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           counted_o;
  logic [COUNT_W-1:0]             bin_count_o;
  logic                           bin_included_o;
  logic [COUNT_W-1:0]             total_count_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [bhf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [bhf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int failures;
  int pending;
  int results;

  // idling switches, changed per phase
  bit send_idle;
  bit recv_idle;

  int unsigned requests_sent;
  int unsigned reg_writes;
  int unsigned settings_used;

  byte_histogram_with_filter #(
    .CountWidth(COUNT_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .bin_index_i   (bin_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .counted_o     (counted_o),
    .bin_count_o   (bin_count_o),
    .bin_included_o(bin_included_o),
    .total_count_o (total_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // watches all three channels beside the block
  byte_histogram_with_filter_checker #(
    .CountWidth(COUNT_W)
  ) hist_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .bin_index_i   (bin_index_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .counted_i     (counted_o),
    .bin_count_i   (bin_count_o),
    .bin_included_i(bin_included_o),
    .total_count_i (total_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .failures_o    (failures),
    .pending_o     (pending),
    .results_o     (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: draws a stall per result, then holds ready until one is taken
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(STALL_MAX, 0) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  // ends the run if no request moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
    $display("byte_histogram_with_filter verification failed");
    $finish;
  end

  // one request; called at a falling edge and returns at one
  task automatic push_request(bhf_pkg::action_e act, logic [7:0] raw, logic [7:0] idx);
    int unsigned gap;
    gap = send_idle ? $urandom_range(STALL_MAX, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= raw;
    bin_index_i <= idx;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
    requests_sent++;
  endtask

  // leaves cfg_valid_i high; program_settings lowers it after the last write
  task automatic write_reg(logic [bhf_pkg::CFG_IDX_W-1:0] idx,
                           logic [bhf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    reg_writes++;
  endtask

  // full register set, optionally followed by a write to an unmapped index
  task automatic program_settings(logic [1:0] mode, logic [63:0] m0, logic [63:0] m1,
                                  logic [63:0] m2, logic [63:0] m3, bit stray);
    logic [bhf_pkg::CFG_DATA_W-1:0] mode_word;
    mode_word      = {$urandom, $urandom};
    mode_word[1:0] = mode;
    // upper bits of the mode word are junk and must be dropped
    write_reg(bhf_pkg::CFG_CASE_MODE, mode_word);
    write_reg(bhf_pkg::CFG_MASK_0, m0);
    write_reg(bhf_pkg::CFG_MASK_1, m1);
    write_reg(bhf_pkg::CFG_MASK_2, m2);
    write_reg(bhf_pkg::CFG_MASK_3, m3);
    // last, so that a wrongly decoded index would clobber a live mask
    if (stray) begin
      write_reg(IDX_W'($urandom_range((1 << IDX_W) - 1, bhf_pkg::CFG_MASK_3 + 1)),
                {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_mask();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, $urandom};
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  // half fully random bytes, half ascii letters of either case
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    if ($urandom_range(1, 0) == 0) begin
      b = 8'($urandom_range(255, 0));
    end else begin
      b = bhf_pkg::UPPER_LO + 8'($urandom_range(25, 0));
      if ($urandom_range(1, 0) == 1) b = b + bhf_pkg::CASE_DELTA;
    end
    return b;
  endfunction

  initial begin : stimulus
    bhf_pkg::action_e act;
    logic [1:0]       mode;
    logic [63:0]      one_hole;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = bhf_pkg::ACT_COUNT;
    data_byte_i   = '0;
    bin_index_i   = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = bhf_pkg::CFG_CASE_MODE;
    cfg_data_i    = '0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    requests_sent = 0;
    reg_writes    = 0;
    settings_used = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: no folding, every byte included
    // extremes and the letter range edges on both sides
    push_request(bhf_pkg::ACT_COUNT, 8'h00, 8'hFF);
    push_request(bhf_pkg::ACT_COUNT, 8'hFF, 8'h00);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_LO, 8'h5A);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_HI, 8'hA5);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_LO, 8'h3C);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_HI, 8'hC3);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_LO - 8'd1, 8'h01);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_HI + 8'd1, 8'hFE);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_LO - 8'd1, 8'h80);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_HI + 8'd1, 8'h7F);
    push_request(bhf_pkg::ACT_COUNT, 8'h00, 8'h55);
    // reads ignore the data byte; one bin never touched
    push_request(bhf_pkg::ACT_READ, 8'hA5, 8'h00);
    push_request(bhf_pkg::ACT_READ, 8'h5A, 8'hFF);
    push_request(bhf_pkg::ACT_READ, 8'hFF, bhf_pkg::UPPER_LO);
    push_request(bhf_pkg::ACT_READ, 8'h00, 8'h80);

    // fold to lower case with 'a' and the whole low quarter excluded
    drain_results();
    one_hole = ~(64'h1 << (bhf_pkg::LOWER_LO - 8'd64));
    program_settings(bhf_pkg::CASE_LOWER, '0, one_hole, '1, '1, 1'b1);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_LO, 8'hFF);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_HI, 8'h00);
    push_request(bhf_pkg::ACT_COUNT, 8'h00, 8'hAA);
    push_request(bhf_pkg::ACT_READ, 8'hFF, 8'h00);
    push_request(bhf_pkg::ACT_READ, 8'h00, bhf_pkg::LOWER_LO);

    // fold to upper case
    drain_results();
    program_settings(bhf_pkg::CASE_UPPER, '1, '1, '1, '1, 1'b0);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_LO, 8'h00);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_HI, 8'h00);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_LO, 8'h00);
    push_request(bhf_pkg::ACT_READ, 8'h00, bhf_pkg::UPPER_LO);

    // spare mode value folds nothing
    drain_results();
    program_settings(CASE_SPARE, '1, '1, '1, '1, 1'b1);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::LOWER_LO, 8'h00);
    push_request(bhf_pkg::ACT_COUNT, bhf_pkg::UPPER_HI, 8'h00);

    // random phases: first all excluded, then all included, then mixed masks
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      mode = 2'($urandom_range(3, 0));
      if (p == 0) begin
        program_settings(mode, '0, '0, '0, '0, 1'b0);
      end else if (p == 1) begin
        program_settings(mode, '1, '1, '1, '1, 1'b1);
      end else begin
        program_settings(mode, random_mask(), random_mask(), random_mask(),
                         random_mask(), 1'($urandom_range(1, 0)));
      end
      // idling pattern per phase, including a stretch with none at all
      case (p % 4)
        0: begin send_idle = 1'b1; recv_idle = 1'b1; end
        1: begin send_idle = 1'b0; recv_idle = 1'b0; end
        2: begin send_idle = 1'b1; recv_idle = 1'b0; end
        default: begin send_idle = 1'b0; recv_idle = 1'b1; end
      endcase
      repeat (PHASE_ITEMS) begin
        act = ($urandom_range(9, 0) < 3) ? bhf_pkg::ACT_READ : bhf_pkg::ACT_COUNT;
        push_request(act, pick_byte(), pick_byte());
      end
    end

    drain_results();

    $display("run covered %0d requests under all case modes and %0d register writes",
             requests_sent, reg_writes);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_used, results, failures);
    if (failures == 0 && pending == 0) begin
      $display("byte_histogram_with_filter verification clean");
    end else begin
      $display("byte_histogram_with_filter verification failed");
    end
    $finish;
  end

endmodule
